FILE: sv/utf8v_pkg.sv
// Package with the byte class constants and the sequence state type of the UTF-8 validator.
package utf8v_pkg;

    localparam int unsigned BYTE_W = 8;

    // Lead byte boundaries and the continuation byte pattern.
    localparam logic [BYTE_W-1:0] LEAD_TWO_MIN   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_TWO_LOW   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_THREE_LOW = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_BAD_LOW   = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK      = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PATTERN   = 8'h80;

    // What the next byte of the message must be.
    typedef enum logic [1:0] {
        PEND_LEAD      = 2'd0,  // a lead or a single byte
        PEND_FINAL     = 2'd1,  // the last continuation of a sequence
        PEND_FIRST     = 2'd2,  // the first of two continuations
        PEND_BAD_FINAL = 2'd3   // third byte after a bad first continuation
    } pend_t;

endpackage

FILE: sv/utf8_stream_validator_core.sv
// Top level of the streaming UTF-8 validator with its result buffer.
//
//  Channel | Direction | Ports                              | Request carries
//  --------+-----------+------------------------------------+--------------------------
//  s_      | in        | s_valid s_ready s_byte_value       | one message byte and the
//          |           | s_last_byte                        | flag on the final byte
//  m_      | out       | m_valid m_ready m_is_valid         | verdict for one message
//
// One byte is taken in every clock cycle while s_ready is high; a message's
// verdict is registered in the output register, or the skid entry if that is held.
// The sequence state and the sticky error flag feed back into their own
// update, which is a single comparison and selection.
// Reset (aresetn, synchronous, active low) clears the sequence state and both
// result buffer entries; it needs no clearing pass.
// A stalled m_ side does not stop the input: the output register and a skid
// entry hold up to two verdicts, and s_ready falls only once both are full.
module utf8_stream_validator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [utf8v_pkg::BYTE_W-1:0]    s_byte_value,
    input  logic                            s_last_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_is_valid
);
    import utf8v_pkg::*;

    pend_t pend_reg, pend_next;
    logic  err_reg, err_next;

    // Result register and skid entry.
    logic out_valid_reg, out_valid_next;
    logic out_ok_reg, out_ok_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_ok_reg, skid_ok_next;

    // Per-byte evaluation.
    pend_t pend_after;
    logic  err_after;
    logic  is_cont;
    logic  in_take;
    logic  verdict_push;
    logic  verdict_ok;
    logic  out_take;

    assign in_take  = s_valid && s_ready;
    assign out_take = out_valid_reg && m_ready;
    assign is_cont  = (s_byte_value & CONT_MASK) == CONT_PATTERN;

    // Sequence state after this byte, before the end of message clears it.
    // Once an error is seen the remaining bytes of the message are ignored.
    always_comb begin
        pend_after = pend_reg;
        err_after  = err_reg;
        if (!err_reg) begin
            case (pend_reg)
                PEND_FINAL: begin
                    if (!is_cont) begin
                        err_after = 1'b1;
                    end
                    pend_after = PEND_LEAD;
                end
                PEND_FIRST: begin
                    pend_after = is_cont ? PEND_FINAL : PEND_BAD_FINAL;
                end
                PEND_BAD_FINAL: begin
                    // The bad first continuation counts only once a third byte arrives.
                    err_after  = 1'b1;
                    pend_after = PEND_LEAD;
                end
                default: begin
                    if (s_byte_value < LEAD_TWO_MIN) begin
                        pend_after = PEND_LEAD;
                    end else if (s_byte_value < LEAD_TWO_LOW) begin
                        err_after = 1'b1;
                    end else if (s_byte_value < LEAD_THREE_LOW) begin
                        pend_after = PEND_FINAL;
                    end else if (s_byte_value < LEAD_BAD_LOW) begin
                        pend_after = PEND_FIRST;
                    end else begin
                        err_after = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next state: the last byte of a message returns everything to the start.
    always_comb begin
        pend_next = pend_reg;
        err_next  = err_reg;
        if (in_take) begin
            if (s_last_byte) begin
                pend_next = PEND_LEAD;
                err_next  = 1'b0;
            end else begin
                pend_next = pend_after;
                err_next  = err_after;
            end
        end
    end

    // Outputs of the evaluation: a verdict is produced on the last byte only.
    // A message cut short inside a sequence still passes.
    always_comb begin
        verdict_push = in_take && s_last_byte;
        verdict_ok   = !err_after;
    end

    // Result buffer. The skid entry fills only when the output register is
    // held by a stalled request; it drains into the output register first.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        skid_valid_next = skid_valid_reg;
        skid_ok_next    = skid_ok_reg;
        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_ok_next     = skid_ok_reg;
                skid_valid_next = verdict_push;
                skid_ok_next    = verdict_ok;
            end else begin
                out_valid_next = verdict_push;
                out_ok_next    = verdict_ok;
            end
        end else if (verdict_push) begin
            skid_valid_next = 1'b1;
            skid_ok_next    = verdict_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= PEND_LEAD;
            err_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            pend_reg       <= pend_next;
            err_reg        <= err_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg  <= out_ok_next;
        skid_ok_reg <= skid_ok_next;
    end

    assign s_ready    = !skid_valid_reg;
    assign m_valid    = out_valid_reg;
    assign m_is_valid = out_ok_reg;

endmodule

FILE: sv/utf8v_checker.sv
// Port-level assertion checker for the UTF-8 validator, with its bind statement.
module utf8v_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [utf8v_pkg::BYTE_W-1:0] s_byte_value,
    input logic                         s_last_byte,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_is_valid
);
    import utf8v_pkg::*;

    logic byte_unused;
    assign byte_unused = ^s_byte_value;

    // No verdict survives a reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("verdict request present after reset");

    // Input back-pressure only arises when verdicts are waiting.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no verdict pending");

    // A byte inside a message never produces a verdict.
    a_no_result_mid_message: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_last_byte && !m_valid && (byte_unused || !byte_unused))
        |=> !m_valid)
        else $error("verdict produced for a byte that is not the last");

    // The last byte of a message, with no verdict waiting, yields a verdict in the next cycle.
    a_result_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_byte && !m_valid) |=> m_valid)
        else $error("no verdict after the last byte of a message");

    // A stalled verdict holds its value.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_is_valid)))
        else $error("stalled verdict request changed or dropped");

endmodule

bind utf8_stream_validator_core utf8v_checker u_utf8v_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the streaming UTF-8 validator core.
module testbench;

    import utf8v_pkg::*;

    // Bytes queued for each idling phase, and the most cycles allowed for the
    // last verdicts to drain at the end.
    localparam int unsigned BYTES_PER_PHASE = 535;
    localparam int unsigned DRAIN_LIMIT     = 2000;

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_byte_value = '0;
    logic                s_last_byte  = 1'b0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic                m_is_valid;

    // One input request as the driver sees it.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } msg_byte_t;

    msg_byte_t   pending_bytes[$];   // requests not yet presented to the block
    logic        verdicts[$];        // expected verdicts, oldest first
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count   = 0;
    int unsigned bytes_queued  = 0;
    int unsigned bytes_sent    = 0;
    int unsigned verdicts_seen = 0;
    int unsigned valid_seen    = 0;

    // Our own copy of the sequence state and of the sticky error flag.
    pend_t seq_state = PEND_LEAD;
    logic  msg_error = 1'b0;

    utf8_stream_validator_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_valid   (m_is_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A hard stop, far beyond the slowest correct run.
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // Advances the sequence state by one accepted byte and, on the final byte
    // of a message, records the verdict that the block must return for it.
    task automatic predict_verdict(input logic [BYTE_W-1:0] b, input logic last);
        logic is_cont;
        is_cont = ((b & CONT_MASK) == CONT_PATTERN);
        // Once an error has been seen, the rest of the message is ignored.
        if (!msg_error) begin
            case (seq_state)
                PEND_FINAL: begin
                    if (!is_cont) msg_error = 1'b1;
                    seq_state = PEND_LEAD;
                end
                PEND_FIRST: begin
                    // A bad first continuation is only punished on the third byte.
                    seq_state = is_cont ? PEND_FINAL : PEND_BAD_FINAL;
                end
                PEND_BAD_FINAL: begin
                    msg_error = 1'b1;
                    seq_state = PEND_LEAD;
                end
                default: begin
                    if (b >= LEAD_TWO_MIN) begin
                        if (b < LEAD_TWO_LOW) begin
                            msg_error = 1'b1;      // stray continuation as a lead
                        end else if (b < LEAD_THREE_LOW) begin
                            seq_state = PEND_FINAL;
                        end else if (b < LEAD_BAD_LOW) begin
                            seq_state = PEND_FIRST;
                        end else begin
                            msg_error = 1'b1;      // four-byte leads and above
                        end
                    end
                end
            endcase
        end
        // A sequence cut short by the end of the message is accepted.
        if (last) begin
            verdicts.push_back(!msg_error);
            seq_state = PEND_LEAD;
            msg_error = 1'b0;
        end
    endtask

    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last);
        msg_byte_t item;
        item.value = b;
        item.last  = last;
        pending_bytes.push_back(item);
        bytes_queued++;
    endtask

    // Queues a whole message given as a list of bytes, flagging the last one.
    task automatic queue_message(input logic [BYTE_W-1:0] bytes[$]);
        foreach (bytes[i]) queue_byte(bytes[i], i == bytes.size() - 1);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Builds a random message: mostly well-formed characters with random
    // content, with some stray bytes, broken sequences and cut-short endings.
    task automatic queue_random_message();
        logic [BYTE_W-1:0] bytes[$];
        int unsigned       n_chars;
        int unsigned       pick;
        int unsigned       last_len;
        n_chars  = $urandom_range(1, 6);
        last_len = 1;
        for (int unsigned c = 0; c < n_chars; c++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                bytes.push_back(BYTE_W'($urandom_range(8'h00, 8'h7F)));
                last_len = 1;
            end else if (pick < 60) begin
                bytes.push_back(BYTE_W'($urandom_range(8'hC0, 8'hDF)));
                bytes.push_back(cont_byte());
                last_len = 2;
            end else if (pick < 82) begin
                bytes.push_back(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
                bytes.push_back(cont_byte());
                bytes.push_back(cont_byte());
                last_len = 3;
            end else if (pick < 87) begin
                bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hFF)));
                last_len = 1;
            end else if (pick < 94) begin
                // A lead followed by arbitrary bytes that may break the sequence.
                bytes.push_back(BYTE_W'($urandom_range(8'hC0, 8'hEF)));
                bytes.push_back(BYTE_W'($urandom));
                bytes.push_back(BYTE_W'($urandom));
                last_len = 1;
            end else begin
                bytes.push_back(BYTE_W'($urandom));
                last_len = 1;
            end
        end
        // Now and then the message ends in the middle of its last character.
        if (last_len > 1 && $urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, last_len - 1)) void'(bytes.pop_back());
        end
        queue_message(bytes);
    endtask

    // Short directed messages: the byte class boundaries and the special cases.
    task automatic queue_directed();
        logic [BYTE_W-1:0] bounds[$];
        bounds = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hC0, 8'hDF, 8'hE0, 8'hEF, 8'hF0, 8'hFF};
        foreach (bounds[i]) queue_byte(bounds[i], 1'b1);     // one-byte messages
        queue_message('{8'hC3, 8'hA9});                       // two-byte character
        queue_message('{8'hE2, 8'h82, 8'hAC});                // three-byte character
        queue_message('{8'hE2, 8'h41});                       // bad first cont, cut short
        queue_message('{8'hE2, 8'h41, 8'h41});                // bad first cont, third byte
        queue_message('{8'h80, 8'h41});                       // error, then ignored byte
        queue_message('{8'hC3, 8'h41});                       // bad final continuation
        queue_byte(8'hC3, 1'b1);                              // two-byte lead cut short
    endtask

    // Driver. A request stays on the port until it is accepted, and a new one
    // is only presented once the slot has been freed, so s_valid is assigned
    // at most once per edge.
    always @(posedge aclk) begin
        msg_byte_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_verdict(s_byte_value, s_last_byte);
                bytes_sent++;
            end
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                item = pending_bytes.pop_front();
                s_valid      <= 1'b1;
                s_byte_value <= item.value;
                s_last_byte  <= item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor. Each accepted verdict is matched against the oldest expectation.
    always @(posedge aclk) begin
        logic expected;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: verdict %0b arrived with none expected", $time, m_is_valid);
                    error_count++;
                end else begin
                    expected = verdicts.pop_front();
                    verdicts_seen++;
                    if (expected) valid_seen++;
                    if (m_is_valid !== expected) begin
                        $display("%0t: is_valid mismatch, expected %0b, actual %0b",
                                 $time, expected, m_is_valid);
                        error_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Waits until every queued request has been accepted by the block.
    task automatic wait_sent();
        while (bytes_sent != bytes_queued) @(posedge aclk);
    endtask

    initial begin
        int unsigned drain_cycles;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // First phase: a lazy receiver facing a mostly eager sender.
        send_idle_pct = 15;
        recv_idle_pct = 65;
        queue_directed();
        while (bytes_queued < BYTES_PER_PHASE) queue_random_message();
        wait_sent();

        // Second phase: the roles swap, so the sender leaves most of the gaps.
        send_idle_pct = 65;
        recv_idle_pct = 15;
        while (bytes_queued < 2 * BYTES_PER_PHASE) queue_random_message();
        wait_sent();

        // Third phase: a request and a verdict may move on every cycle.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (bytes_queued < 3 * BYTES_PER_PHASE) queue_random_message();
        wait_sent();

        // Let the last verdicts drain, then a few extra cycles for strays.
        drain_cycles = 0;
        while (verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (10) @(posedge aclk);
        if (verdicts.size() != 0) begin
            $display("%0t: %0d expected verdicts never arrived", $time, verdicts.size());
            error_count++;
        end

        $display("Sent %0d bytes under three idling patterns; %0d verdicts checked, %0d valid.",
                 bytes_sent, verdicts_seen, valid_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/utf8v_pkg.sv
sv/utf8_stream_validator_core.sv
sv/utf8v_checker.sv
tb/testbench.sv
